// ===== sv/aes128_pkg.sv =====
// Package with the AES-128 S-box, round constants and byte helpers.
`default_nettype none
package aes128_pkg;
	localparam int NumRounds = 10;
	localparam int AddrWidth = 4;
	localparam logic [AddrWidth-1:0] RegKeyHigh = 4'h0;
	localparam logic [AddrWidth-1:0] RegKeyLow  = 4'h8;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] tbl [0:255];
		tbl = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return tbl[a];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1B;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
	endfunction

	// Byte k of a 128-bit block, byte 0 at the top.
	function automatic logic [7:0] byte_of(input logic [127:0] b, input int k);
		return b[127-8*k -: 8];
	endfunction
endpackage
`default_nettype wire

// ===== sv/aes128_round_cell.sv =====
// One round cell: expands its round key and applies one AES round to its block.
`default_nettype none
module aes128_round_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [3:0]   round,
	input  wire logic         valid_in,
	input  wire logic [127:0] state_in,
	input  wire logic [127:0] key_in,
	output logic              valid_out,
	output logic [127:0]      state_out,
	output logic [127:0]      key_out
);
	logic [127:0] rk;
	logic [127:0] ss;
	logic [127:0] mc;
	logic [31:0]  tw;
	logic [31:0]  w0, w1, w2, w3;

	always_comb begin
		tw = {aes128_pkg::sbox(key_in[23:16]) ^ aes128_pkg::rcon(round),
			aes128_pkg::sbox(key_in[15:8]), aes128_pkg::sbox(key_in[7:0]),
			aes128_pkg::sbox(key_in[31:24])};
		w0 = key_in[127:96] ^ tw;
		w1 = key_in[95:64] ^ w0;
		w2 = key_in[63:32] ^ w1;
		w3 = key_in[31:0] ^ w2;
		rk = {w0, w1, w2, w3};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				ss[127-8*(4*c+r) -: 8] =
					aes128_pkg::sbox(aes128_pkg::byte_of(state_in, 4*((c+r)%4)+r));
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = ss[127-32*c -: 8];
			a1 = ss[119-32*c -: 8];
			a2 = ss[111-32*c -: 8];
			a3 = ss[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 8] = a0 ^ al ^ aes128_pkg::xtime(a0 ^ a1);
			mc[119-32*c -: 8] = a1 ^ al ^ aes128_pkg::xtime(a1 ^ a2);
			mc[111-32*c -: 8] = a2 ^ al ^ aes128_pkg::xtime(a2 ^ a3);
			mc[103-32*c -: 8] = a3 ^ al ^ aes128_pkg::xtime(a3 ^ a0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		state_out <= ((round == 4'(aes128_pkg::NumRounds)) ? ss : mc) ^ rk;
		key_out   <= rk;
	end
endmodule
`default_nettype wire

// ===== sv/aes128_block_encrypt_core.sv =====
// Top level: key registers, APB port and a chain of ten AES round cells.
// The done strobe follows the accepted start beat through the input register and then each round cell in turn.
// Throughput: one block per cycle; busy is always low.
// Each block carries its own round keys along the cell chain.
// Reset clears both key registers and all in-flight valid bits.
`default_nettype none
module aes128_block_encrypt_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,
	output logic             done,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low
);
	logic [63:0]  key_high_q, key_low_q;
	logic         v_s [0:aes128_pkg::NumRounds];
	logic [127:0] st_s [0:aes128_pkg::NumRounds];
	logic [127:0] k_s [0:aes128_pkg::NumRounds];

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_comb begin
		case (paddr)
			aes128_pkg::RegKeyHigh: prdata = key_high_q;
			aes128_pkg::RegKeyLow:  prdata = key_low_q;
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			v_s[0]     <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == aes128_pkg::RegKeyHigh) key_high_q <= pwdata;
				if (paddr == aes128_pkg::RegKeyLow)  key_low_q  <= pwdata;
			end
			v_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		st_s[0] <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
		k_s[0]  <= {key_high_q, key_low_q};
	end

	for (genvar g = 1; g <= aes128_pkg::NumRounds; g++) begin : g_cell
		aes128_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.round    (4'(g)),
			.valid_in (v_s[g-1]),
			.state_in (st_s[g-1]),
			.key_in   (k_s[g-1]),
			.valid_out(v_s[g]),
			.state_out(st_s[g]),
			.key_out  (k_s[g])
		);
	end

	assign done        = v_s[aes128_pkg::NumRounds];
	assign cipher_high = st_s[aes128_pkg::NumRounds][127:64];
	assign cipher_low  = st_s[aes128_pkg::NumRounds][63:0];
endmodule
`default_nettype wire
